FILE: rtl/core/sase_pkg.sv
// ----------------------------------------------------------------------------
// sase_pkg
// Shared types, constants and helpers for the epoch-stamped set-all array.
// ----------------------------------------------------------------------------
package sase_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int EPOCH_WIDTH_DEF = 16;

  localparam int CMD_W       = 2;
  localparam int INDEX_W     = 10;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [VALUE_W-1:0] GLOBAL_VALUE_RST = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_SET     = 2'd1,
    CMD_READ    = 2'd2,
    CMD_SET_ALL = 2'd3
  } command_t;

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // read_value [31:0], is_full [32], rejected [33], fill_count [44:34]
  function automatic logic [OUT_TDATA_W-1:0] pack_result(
    input logic [VALUE_W-1:0] read_value,
    input logic               is_full,
    input logic               rejected,
    input logic [COUNT_W-1:0] fill_count
  );
    return {3'b000, fill_count, rejected, is_full, read_value};
  endfunction

endpackage

FILE: rtl/core/sase_ram.sv
// ----------------------------------------------------------------------------
// sase_ram
// Single-clock store of value and stamp words, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module sase_ram
  import sase_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = VALUE_W + EPOCH_WIDTH_DEF,
  parameter int AW    = addr_bits(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/sase_sweep.sv
// ----------------------------------------------------------------------------
// sase_sweep
// Clearing pass over the store: one entry a cycle, after reset and on
// request at epoch wrap.
// ----------------------------------------------------------------------------
module sase_sweep
  import sase_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = addr_bits(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic [AW-1:0] addr
);

  typedef enum logic [1:0] {
    SW_IDLE  = 2'b01,
    SW_CLEAR = 2'b10
  } sweep_state_t;

  sweep_state_t state;
  logic         last;

  assign last = (addr == AW'(DEPTH - 1));
  assign busy = (state == SW_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SW_CLEAR;
      addr  <= '0;
    end else begin
      unique case (state)
        SW_IDLE: begin
          if (start) begin
            state <= SW_CLEAR;
            addr  <= '0;
          end
        end
        SW_CLEAR: begin
          if (last) begin
            state <= SW_IDLE;
          end
          addr <= addr + 1'b1;
        end
        default: begin
          state <= SW_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/set_all_array_epoch_store.sv
// ----------------------------------------------------------------------------
// set_all_array_epoch_store
// Array with constant-time set-all built on one epoch-stamped memory.
// ----------------------------------------------------------------------------
// Append, set and set-all register their result directly; a read is first
// registered in the store's read port. After reset, and on the set-all
// that finds the epoch at its maximum (every 2^EPOCH_WIDTH - 2 set-alls), a
// clearing pass writes every stamp to zero, one entry a cycle, while no
// transaction is accepted. A new transaction is taken only when the output
// register is empty or its result leaves in that cycle.
module set_all_array_epoch_store
  import sase_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int EPOCH_WIDTH = EPOCH_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // index [9:0], value [41:10]
  input  logic [CMD_W-1:0]       s_tuser,  // command [1:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // read_value, is_full, rejected, fill_count
);

  localparam int AW = addr_bits(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam int MW = VALUE_W + EPOCH_WIDTH;
  localparam logic [EPOCH_WIDTH-1:0] EPOCH_MAX = {{(EPOCH_WIDTH-1){1'b1}}, 1'b0};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } ctrl_state_t;

  ctrl_state_t            state;
  logic [PW-1:0]          pos;
  logic [PW-1:0]          pos_next;
  logic [EPOCH_WIDTH-1:0] epoch;
  logic [EPOCH_WIDTH-1:0] stamp_new;
  logic [VALUE_W-1:0]     global_value;
  logic                   rd_in_range;

  command_t               cmd;
  logic [INDEX_W-1:0]     index;
  logic [VALUE_W-1:0]     value;
  logic                   accept;
  logic                   in_range;
  logic                   full;
  logic                   full_next;
  logic                   reject;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [MW-1:0]          mem_wdata;
  logic                   mem_re;
  logic [MW-1:0]          mem_rdata;
  logic [VALUE_W-1:0]     rd_value;

  logic                   sweep_start;
  logic                   sweep_busy;
  logic [AW-1:0]          sweep_addr;

  assign cmd   = command_t'(s_tuser);
  assign index = s_tdata[INDEX_W-1:0];
  assign value = s_tdata[INDEX_W +: VALUE_W];

  assign s_tready = (state == ST_IDLE) && !sweep_busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign in_range  = (32'(index) < DEPTH);
  assign full      = (pos >= PW'(DEPTH));
  assign stamp_new = epoch + 1'b1;
  assign reject    = (cmd == CMD_APPEND) && full;
  assign pos_next  = ((cmd == CMD_APPEND) && !full) ? pos + 1'b1 : pos;
  assign full_next = (pos_next >= PW'(DEPTH));

  assign sweep_start = accept && (cmd == CMD_SET_ALL) && (epoch >= EPOCH_MAX);

  assign mem_re = accept && (cmd == CMD_READ);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = '0;
    if (sweep_busy) begin
      mem_we = 1'b1;
    end else if (accept) begin
      unique case (cmd)
        CMD_APPEND: begin
          mem_we    = !full;
          mem_waddr = AW'(pos);
          mem_wdata = {stamp_new, value};
        end
        CMD_SET: begin
          mem_we    = in_range;
          mem_waddr = AW'(index);
          mem_wdata = {stamp_new, value};
        end
        CMD_READ, CMD_SET_ALL: begin
          mem_we = 1'b0;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // stamp match means the entry was written since the last set-all
  assign rd_value = (rd_in_range && (mem_rdata[VALUE_W +: EPOCH_WIDTH] == stamp_new)) ?
                    mem_rdata[VALUE_W-1:0] : global_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pos          <= '0;
      epoch        <= '0;
      global_value <= GLOBAL_VALUE_RST;
      m_tvalid     <= 1'b0;
    end else begin
      if ((accept && (cmd != CMD_READ)) || (state == ST_READ)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pos <= pos_next;
            if (cmd == CMD_READ) begin
              state <= ST_READ;
            end
            if (cmd == CMD_SET_ALL) begin
              global_value <= value;
              epoch        <= (epoch >= EPOCH_MAX) ? EPOCH_WIDTH'(1) : stamp_new;
            end
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_in_range <= in_range;
    end
    if (state == ST_READ) begin
      m_tdata <= pack_result(rd_value, full, 1'b0, COUNT_W'(pos));
    end else if (accept && (cmd != CMD_READ)) begin
      m_tdata <= pack_result('0, full_next, reject, COUNT_W'(pos_next));
    end
  end

  sase_ram #(
    .DEPTH (DEPTH),
    .WIDTH (MW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (AW'(index)),
    .rdata (mem_rdata)
  );

  sase_sweep #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_sweep (
    .clk   (clk),
    .rst   (rst),
    .start (sweep_start),
    .busy  (sweep_busy),
    .addr  (sweep_addr)
  );

endmodule

FILE: rtl/core/sase_checker.sv
// ----------------------------------------------------------------------------
// sase_checker
// Port-level checks for the epoch-stamped set-all array.
// ----------------------------------------------------------------------------
module sase_checker
  import sase_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic seen_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_full <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[VALUE_W]) begin
      seen_full <= 1'b1;
    end
  end

  // a rejected append only happens on a full array
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[VALUE_W+1] |-> m_tdata[VALUE_W])
    else $error("rejected without full");

  // once full, the array stays full until reset
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_full |-> m_tdata[VALUE_W])
    else $error("full flag dropped");

  // a new transaction is only taken when the result slot frees up
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || m_tready)
    else $error("input taken while result blocked");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind set_all_array_epoch_store sase_checker u_sase_checker (.*);

FILE: dv/sase_result_checker.sv
// ----------------------------------------------------------------------------
// sase_result_checker
// Watches both stream channels of the epoch-stamped set-all array, keeps its
// own copy of the store, epoch and fill position, predicts one result per
// accepted command and compares every field of each returned result in order.
// ----------------------------------------------------------------------------
module sase_result_checker
  import sase_pkg::*;
#(
  parameter int STAMP_W = EPOCH_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // index [9:0], value [41:10]
  input  logic [CMD_W-1:0]       s_tuser,   // command [1:0]
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // read_value, is_full, rejected, fill_count
  output int                     errors,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [STAMP_W-1:0]     EPOCH_MAX = STAMP_W'(2 ** STAMP_W - 2);

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               is_full;
    logic               rejected;
    logic [COUNT_W-1:0] fill_count;
  } array_result_t;

  logic [VALUE_W-1:0] value_mem [DEPTH_DEF];
  logic [STAMP_W-1:0] stamp_mem [DEPTH_DEF];
  logic [STAMP_W-1:0] epoch;
  logic [VALUE_W-1:0] all_value;
  logic [COUNT_W-1:0] fill_pos;
  array_result_t      results_q [$];
  int                 fail_cnt = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic void store_entry(input logic [COUNT_W-1:0] pos,
                                      input logic [VALUE_W-1:0] val);
    value_mem[pos[INDEX_W-1:0]] = val;
    stamp_mem[pos[INDEX_W-1:0]] = epoch + STAMP_W'(1);
  endfunction

  function automatic array_result_t apply_command(input command_t           cmd,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic [VALUE_W-1:0] val);
    array_result_t      r;
    logic [STAMP_W-1:0] live_stamp;
    r = '0;
    live_stamp = epoch + STAMP_W'(1);
    case (cmd)
      CMD_APPEND: begin
        if (fill_pos >= COUNT_W'(DEPTH_DEF)) begin
          r.rejected = 1'b1;
        end else begin
          store_entry(fill_pos, val);
          fill_pos = fill_pos + COUNT_W'(1);
        end
      end
      CMD_SET: begin
        store_entry(COUNT_W'(idx), val);
      end
      CMD_READ: begin
        r.read_value = (stamp_mem[idx] == live_stamp) ? value_mem[idx] : all_value;
      end
      default: begin
        all_value = val;
        if (epoch >= EPOCH_MAX) begin
          // epoch wrap: all stamps go stale together
          foreach (stamp_mem[k]) stamp_mem[k] = '0;
          epoch = '0;
        end
        epoch = epoch + STAMP_W'(1);
      end
    endcase
    r.is_full    = (fill_pos >= COUNT_W'(DEPTH_DEF));
    r.fill_count = fill_pos;
    return r;
  endfunction

  always @(posedge clk) begin
    array_result_t want;
    array_result_t got;
    if (rst) begin
      foreach (stamp_mem[k]) begin
        stamp_mem[k] = '0;
        value_mem[k] = '0;
      end
      epoch     = '0;
      all_value = GLOBAL_VALUE_RST;
      fill_pos  = '0;
      results_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        results_q.push_back(apply_command(command_t'(s_tuser), s_tdata[INDEX_W-1:0],
                                          s_tdata[INDEX_W +: VALUE_W]));
      end
      if (m_tvalid && m_tready) begin
        got.read_value = m_tdata[VALUE_W-1:0];
        got.is_full    = m_tdata[VALUE_W];
        got.rejected   = m_tdata[VALUE_W+1];
        got.fill_count = m_tdata[VALUE_W+2 +: COUNT_W];
        if (results_q.size() == 0) begin
          $error("unexpected result transaction: %h", m_tdata);
          fail_cnt++;
        end else begin
          want = results_q.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            fail_cnt++;
          end
          if (got.is_full !== want.is_full) begin
            $error("is_full: expected %b, got %b", want.is_full, got.is_full);
            fail_cnt++;
          end
          if (got.rejected !== want.rejected) begin
            $error("rejected: expected %b, got %b", want.rejected, got.rejected);
            fail_cnt++;
          end
          if (got.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
            fail_cnt++;
          end
        end
      end
    end
    pending <= results_q.size();
    errors  <= fail_cnt;
  end

endmodule

FILE: dv/tb_set_all_array_epoch_store.sv
// ----------------------------------------------------------------------------
// tb_set_all_array_epoch_store
// Drives directed and random command streams into the set-all array with
// random idling on both channels, a long output hold-off, a fill past full
// and a run of set-alls that forces the epoch wrap and its clearing pass.
// ----------------------------------------------------------------------------
module tb_set_all_array_epoch_store;
  import sase_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // narrow epoch so that wraps and clearing passes come often
  localparam int EPOCH_W      = 4;
  localparam int CYCLE_LIMIT  = 900_000;
  localparam int WRAP_SETALLS = 2 ** EPOCH_W - 2;
  localparam int RANDOM_ITEMS = 1800;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [CMD_W-1:0]       s_tuser  = CMD_APPEND;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int   errors;
  int   pending;
  int   cycles       = 0;
  logic quiet        = 1'b0;
  int   appends_sent = 0;
  int   setalls_sent = 0;
  logic tx_busy      = 1'b0;

  // receiver side
  int   results_seen = 0;
  int   rx_gap       = 0;
  int   long_hold    = 0;
  logic hold_done    = 1'b0;
  int   rx_rate      = 1;

  always #5 clk = ~clk;

  set_all_array_epoch_store #(
    .EPOCH_WIDTH (EPOCH_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sase_result_checker #(
    .STAMP_W  (EPOCH_W)
  ) checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) results_seen <= results_seen + 1;
    if (cycles % 128 == 0) rx_rate <= $urandom_range(0, 2);
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      m_tready  <= (long_hold == 1);
    end else if (!hold_done && results_seen == 400) begin
      hold_done <= 1'b1;
      long_hold <= 200;
      m_tready  <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap   <= rx_gap - 1;
      m_tready <= (rx_gap == 1);
    end else if (!quiet && rx_rate != 0 && $urandom_range(0, 4 * rx_rate) == 0) begin
      rx_gap   <= $urandom_range(1, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst;
    end
  end

  task automatic send(input command_t cmd, input logic [INDEX_W-1:0] idx,
                      input logic [VALUE_W-1:0] val);
    if ($urandom_range(0, 39) == 0) tx_busy = !tx_busy;
    if (!quiet && tx_busy && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(IN_TDATA_W - INDEX_W - VALUE_W){1'b0}}, val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_APPEND) appends_sent++;
    if (cmd == CMD_SET_ALL) setalls_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int                 pick;
    int                 hot_base;
    command_t           cmd;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, unwritten reads, stale stamps
    send(CMD_READ,    10'd0,    32'h1234_5678);
    send(CMD_READ,    10'd1023, 32'h0);
    send(CMD_APPEND,  10'd1023, 32'h7FFF_FFFF);
    send(CMD_APPEND,  10'd0,    32'h8000_0000);
    send(CMD_SET,     10'd1023, 32'h0000_0000);
    send(CMD_SET,     10'd0,    32'hFFFF_FFFF);
    send(CMD_READ,    10'd0,    32'h0);
    send(CMD_READ,    10'd1,    32'h0);
    send(CMD_READ,    10'd1023, 32'hFFFF_FFFF);
    send(CMD_READ,    10'd2,    32'h0);
    send(CMD_SET_ALL, 10'd0,    32'h8000_0000);
    send(CMD_READ,    10'd0,    32'h0);
    send(CMD_READ,    10'd1023, 32'h0);
    send(CMD_APPEND,  10'd0,    32'h0000_0005);
    send(CMD_SET,     10'd1000, 32'hA5A5_5A5A);
    send(CMD_READ,    10'd2,    32'h0);
    send(CMD_READ,    10'd1000, 32'h0);
    send(CMD_SET_ALL, 10'd1023, 32'h7FFF_FFFF);
    send(CMD_SET,     10'd512,  32'h5555_5555);
    send(CMD_READ,    10'd512,  32'h0);
    send(CMD_READ,    10'd511,  32'h0);
    send(CMD_SET_ALL, 10'd341,  32'h0000_0000);
    send(CMD_READ,    10'd512,  32'h0);
    send(CMD_READ,    10'd1000, 32'h0);

    hot_base = 0;
    for (int n = 0; n < RANDOM_ITEMS || appends_sent < DEPTH_DEF + 40; n++) begin
      if (n == 900) drain();
      if ($urandom_range(0, 31) == 0) hot_base = $urandom_range(0, DEPTH_DEF - 16);
      pick = $urandom_range(0, 99);
      if (appends_sent < DEPTH_DEF)
        cmd = (pick < 62) ? CMD_APPEND : (pick < 74) ? CMD_SET :
              (pick < 94) ? CMD_READ : CMD_SET_ALL;
      else
        cmd = (pick < 20) ? CMD_APPEND : (pick < 45) ? CMD_SET :
              (pick < 85) ? CMD_READ : CMD_SET_ALL;
      case ($urandom_range(0, 3))
        0:       idx = INDEX_W'($urandom_range(0, DEPTH_DEF - 1));
        1:       idx = INDEX_W'((appends_sent == 0) ? 0 :
                                (appends_sent > DEPTH_DEF) ? DEPTH_DEF - 1 : appends_sent - 1);
        default: idx = INDEX_W'(hot_base + $urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 15))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        3:       val = 32'h0000_0000;
        default: val = $urandom;
      endcase
      send(cmd, idx, val);
    end

    // epoch wrap: bring the epoch to one below its maximum, no idling from here on
    drain();
    quiet <= 1'b1;
    while (setalls_sent % WRAP_SETALLS != WRAP_SETALLS - 1)
      send(CMD_SET_ALL, INDEX_W'($urandom_range(0, DEPTH_DEF - 1)), $urandom);
    send(CMD_SET, 10'd7, 32'h0BAD_F00D);
    send(CMD_SET_ALL, 10'd0, 32'h1357_9BDF);
    send(CMD_SET, 10'd9, 32'hCAFE_0001);
    send(CMD_READ, 10'd7, 32'h0);
    send(CMD_READ, 10'd9, 32'h0);
    send(CMD_READ, 10'd1000, 32'h0);
    send(CMD_SET_ALL, 10'd0, 32'h2468_ACE0);
    send(CMD_READ, 10'd9, 32'h0);
    send(CMD_READ, 10'd7, 32'h0);
    send(CMD_READ, 10'd2, 32'h0);
    send(CMD_READ, 10'd1000, 32'h0);
    send(CMD_SET, 10'd9, 32'h0F0F_F0F0);
    send(CMD_READ, 10'd9, 32'h0);
    send(CMD_APPEND, 10'd0, 32'h1111_1111);
    for (int n = 0; n < 40; n++)
      send((n % 5 == 4) ? CMD_SET_ALL : (n % 3 == 0) ? CMD_SET : CMD_READ,
           INDEX_W'($urandom_range(0, DEPTH_DEF - 1)), $urandom);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
